// ===== hdl/rpcf_pkg.sv =====
// rpcf_pkg: widths, mode codes and register indexes for the rgba pixel colour filter
// no dependencies; compiled first

package rpcf_pkg;

   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int MODE_W     = 3;
   localparam int OFFSET_W   = 9;

   // channel sum of three 8-bit values, and floor(sum/3) by reciprocal multiply
   localparam int SUM_W      = 10;
   localparam int MEAN_RECIP = 683;
   localparam int MEAN_SHIFT = 11;
   localparam int MEAN_PROD_W = 19;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

   typedef enum logic [MODE_W-1:0] {
      MODE_INVERT      = 3'd0,
      MODE_MONO        = 3'd1,
      MODE_NIGHT       = 3'd2,
      MODE_THRESHOLD   = 3'd3,
      MODE_OFFSET      = 3'd4,
      MODE_SWAP_INVERT = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE     = 3'd0,
      CSR_THRESHOLD_RED   = 3'd1,
      CSR_THRESHOLD_GREEN = 3'd2,
      CSR_THRESHOLD_BLUE  = 3'd3,
      CSR_OFFSET_RED      = 3'd4,
      CSR_OFFSET_GREEN    = 3'd5,
      CSR_OFFSET_BLUE     = 3'd6
   } csr_index_type;

endpackage

// ===== hdl/rpcf_channels.sv =====
// rpcf channel interfaces: pixel request, pixel response and register write
// depends on rpcf_pkg for the payload widths

interface rpcf_req_if;
   import rpcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rpcf_rsp_if;
   import rpcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

interface rpcf_csr_if;
   import rpcf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rgba_pixel_color_filter.sv =====
// rgba_pixel_color_filter: three-stage pixel colour filter (invert, mono, night,
// threshold, offset add, swap-invert); depends on rpcf_pkg and rpcf_channels
//
//   port     role    payload
//   req_if   sink    pixel_in  [31:0]
//   rsp_if   source  pixel_out [31:0]
//   csr_if   sink    index [2:0], data [8:0], always ready
//
// one pixel per clock unless rsp stalls; each pixel passes the stage 1, 2 and 3 registers
// stage 1: unpack, channel sum, threshold and saturating offset candidates
// stage 2: sum times reciprocal of three; stage 3: select by mode into the output register
// a stalled stage holds its data, earlier stages fill any empty slot behind it
// synchronous reset clears the stage valid bits and the filter registers; stage data is not reset

module rgba_pixel_color_filter (
   input  logic             clock,
   input  logic             reset,
   rpcf_req_if.sink         req_if,
   rpcf_rsp_if.source       rsp_if,
   rpcf_csr_if.sink         csr_if
);
   import rpcf_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] a;
   } pix_type;

   typedef struct packed {
      pix_type           pix;
      logic [SUM_W-1:0]  sum;
      pix_type           thr;
      pix_type           off;
   } s1_type;

   typedef struct packed {
      pix_type                pix;
      logic [MEAN_PROD_W-1:0] prod;
      pix_type                thr;
      pix_type                off;
   } s2_type;

   // configuration registers
   mode_type                    mode_ff;
   logic [CHAN_W-1:0]           thr_red_ff, thr_green_ff, thr_blue_ff;
   logic signed [OFFSET_W-1:0]  off_red_ff, off_green_ff, off_blue_ff;

   logic    v1_ff, v2_ff, v3_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   logic [PIXEL_W-1:0] out_ff, out_in;
   logic    adv1, adv2, adv3;
   pix_type px;
   logic [CHAN_W-1:0] mean;

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] c,
                                                 input logic [OFFSET_W-1:0] off);
      logic signed [SUM_W-1:0] s;
      s = $signed({2'b00, c}) + $signed({off[OFFSET_W-1], off});
      if (s[SUM_W-1])
         return '0;
      else if (s[SUM_W-2])
         return CHAN_MAX;
      else
         return s[CHAN_W-1:0];
   endfunction

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INVERT;
         thr_red_ff   <= '0;
         thr_green_ff <= '0;
         thr_blue_ff  <= '0;
         off_red_ff   <= '0;
         off_green_ff <= '0;
         off_blue_ff  <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_index_type'(csr_if.index))
            CSR_FILTER_MODE:     mode_ff      <= mode_type'(csr_if.data[MODE_W-1:0]);
            CSR_THRESHOLD_RED:   thr_red_ff   <= csr_if.data[CHAN_W-1:0];
            CSR_THRESHOLD_GREEN: thr_green_ff <= csr_if.data[CHAN_W-1:0];
            CSR_THRESHOLD_BLUE:  thr_blue_ff  <= csr_if.data[CHAN_W-1:0];
            CSR_OFFSET_RED:      off_red_ff   <= $signed(csr_if.data[OFFSET_W-1:0]);
            CSR_OFFSET_GREEN:    off_green_ff <= $signed(csr_if.data[OFFSET_W-1:0]);
            CSR_OFFSET_BLUE:     off_blue_ff  <= $signed(csr_if.data[OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   // a stage moves on when it is empty or its successor moves on
   assign adv3 = !v3_ff || rsp_if.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_if.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_if.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // stage 1
   always_comb begin
      px = pix_type'(req_if.pixel_in);
      s1_in.pix   = px;
      s1_in.sum   = SUM_W'(px.r) + SUM_W'(px.g) + SUM_W'(px.b);
      s1_in.thr.r = (px.r >= thr_red_ff)   ? px.r : '0;
      s1_in.thr.g = (px.g >= thr_green_ff) ? px.g : '0;
      s1_in.thr.b = (px.b >= thr_blue_ff)  ? px.b : '0;
      s1_in.thr.a = px.a;
      s1_in.off.r = sat_add(px.r, off_red_ff);
      s1_in.off.g = sat_add(px.g, off_green_ff);
      s1_in.off.b = sat_add(px.b, off_blue_ff);
      s1_in.off.a = px.a;
   end

   // stage 2: floor(sum/3) = (sum * 683) >> 11, exact for sums up to 765
   always_comb begin
      s2_in.pix  = s1_ff.pix;
      s2_in.thr  = s1_ff.thr;
      s2_in.off  = s1_ff.off;
      s2_in.prod = MEAN_PROD_W'(s1_ff.sum) * MEAN_PROD_W'(MEAN_RECIP);
   end

   // stage 3
   always_comb begin
      mean = s2_ff.prod[MEAN_SHIFT +: CHAN_W];
      case (mode_ff)
         MODE_INVERT:
            out_in = {CHAN_MAX - s2_ff.pix.r, CHAN_MAX - s2_ff.pix.g,
                      CHAN_MAX - s2_ff.pix.b, s2_ff.pix.a};
         MODE_MONO:
            out_in = {mean, mean, mean, {CHAN_W{1'b0}}};
         MODE_NIGHT:
            out_in = {{CHAN_W{1'b0}}, mean, {CHAN_W{1'b0}}, {CHAN_W{1'b0}}};
         MODE_THRESHOLD:
            out_in = s2_ff.thr;
         MODE_OFFSET:
            out_in = s2_ff.off;
         MODE_SWAP_INVERT:
            out_in = {CHAN_MAX - s2_ff.pix.b, CHAN_MAX - s2_ff.pix.g,
                      CHAN_MAX - s2_ff.pix.r, s2_ff.pix.a};
         default:
            out_in = s2_ff.pix;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff  <= s1_in;
      if (adv2) s2_ff  <= s2_in;
      if (adv3) out_ff <= out_in;
   end

   assign rsp_if.valid     = v3_ff;
   assign rsp_if.pixel_out = out_ff;

endmodule

// ===== hdl/rpcf_checker.sv =====
// rpcf_checker: port-level checks on the pixel colour filter, and its bind
// depends on rgba_pixel_color_filter and rpcf_channels

module rpcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic [1:0] cnt_ff, cnt_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // pixels taken in but not yet handed out
   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer && !rsp_xfer)
         cnt_in = cnt_ff + 2'd1;
      else if (!req_xfer && rsp_xfer)
         cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else
         cnt_ff <= cnt_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("response with no pixel in flight");

   a_ready_bubble: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3 |-> req_ready)
      else $error("request stalled with a free pipeline slot");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("pixel not out three cycles after transfer");

endmodule

bind rgba_pixel_color_filter rpcf_checker u_rpcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready)
);

// ===== tb/rpcf_tb_pkg.sv =====
// rpcf_tb_pkg: expected-pixel scoreboard for the rgba pixel colour filter bench
// holds its own copy of the filter registers; depends on rpcf_pkg

package rpcf_tb_pkg;
   import rpcf_pkg::*;

   // codes the block treats as pass-through or ignores
   localparam logic [MODE_W-1:0]    MODE_SPARE_6    = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_SPARE_7    = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   class pixel_filter_scoreboard;
      logic [MODE_W-1:0]  mode;
      logic [CHAN_W-1:0]  thr_red, thr_green, thr_blue;
      int                 off_red, off_green, off_blue;
      logic [PIXEL_W-1:0] expected_pixels[$];
      int                 errors;

      function new();
         mode      = MODE_INVERT;
         thr_red   = '0;
         thr_green = '0;
         thr_blue  = '0;
         off_red   = 0;
         off_green = 0;
         off_blue  = 0;
         errors    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FILTER_MODE:     mode      = data[MODE_W-1:0];
            CSR_THRESHOLD_RED:   thr_red   = data[CHAN_W-1:0];
            CSR_THRESHOLD_GREEN: thr_green = data[CHAN_W-1:0];
            CSR_THRESHOLD_BLUE:  thr_blue  = data[CHAN_W-1:0];
            CSR_OFFSET_RED:      off_red   = $signed(data[OFFSET_W-1:0]);
            CSR_OFFSET_GREEN:    off_green = $signed(data[OFFSET_W-1:0]);
            CSR_OFFSET_BLUE:     off_blue  = $signed(data[OFFSET_W-1:0]);
            default: ;
         endcase
      endfunction

      function logic [CHAN_W-1:0] saturated_sum(logic [CHAN_W-1:0] c, int off);
         int s;
         s = int'(c) + off;
         if (s < 0) return '0;
         if (s > 255) return CHAN_MAX;
         return s[CHAN_W-1:0];
      endfunction

      function logic [PIXEL_W-1:0] filtered_pixel(logic [PIXEL_W-1:0] p);
         logic [CHAN_W-1:0] r, g, b, a, mean;
         logic [SUM_W-1:0]  sum;
         {r, g, b, a} = p;
         sum  = r + g + b;
         mean = sum / 3;
         case (mode)
            MODE_INVERT:      return {CHAN_MAX - r, CHAN_MAX - g, CHAN_MAX - b, a};
            MODE_MONO:        return {mean, mean, mean, 8'h00};
            MODE_NIGHT:       return {8'h00, mean, 8'h00, 8'h00};
            MODE_THRESHOLD:   return {(r >= thr_red)   ? r : 8'h00,
                                      (g >= thr_green) ? g : 8'h00,
                                      (b >= thr_blue)  ? b : 8'h00, a};
            MODE_OFFSET:      return {saturated_sum(r, off_red), saturated_sum(g, off_green),
                                      saturated_sum(b, off_blue), a};
            MODE_SWAP_INVERT: return {CHAN_MAX - b, CHAN_MAX - g, CHAN_MAX - r, a};
            default:          return p;
         endcase
      endfunction

      task report_mismatch(string what, logic [PIXEL_W-1:0] got,
                           logic [PIXEL_W-1:0] want);
         $display("mismatch: %s got %08h expected %08h (mode %0d)", what, got, want, mode);
         errors++;
      endtask

      function void note_pixel(logic [PIXEL_W-1:0] p);
         expected_pixels.push_back(filtered_pixel(p));
      endfunction

      task check_pixel(logic [PIXEL_W-1:0] got);
         logic [PIXEL_W-1:0] want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel_out", got, '0);
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want)
            report_mismatch("pixel_out", got, want);
      endtask

      task flush_leftovers();
         while (expected_pixels.size() != 0)
            report_mismatch("missing pixel_out", 'x, expected_pixels.pop_front());
      endtask

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

endpackage

// ===== tb/rgba_pixel_color_filter_tb.sv =====
// rgba_pixel_color_filter_tb: drives pixels and register writes into the colour filter
// and checks every output pixel; depends on rpcf_pkg, rpcf_channels and rpcf_tb_pkg

module rgba_pixel_color_filter_tb;
   import rpcf_pkg::*;
   import rpcf_tb_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RANDOM_PHASES = 24;
   localparam int PIXELS_PER_PHASE = 25;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;

   rpcf_req_if req_if ();
   rpcf_rsp_if rsp_if ();
   rpcf_csr_if csr_if ();

   pixel_filter_scoreboard sb = new();

   rgba_pixel_color_filter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #800000;
      $display("FAILURE");
      $finish;
   end

   // output side: check on transfer, then pick ready for the next edge
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_pixel(rsp_if.pixel_out);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic set_idling(int profile);
      case (profile)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 62; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 62; end
         default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.index <= idx;
      csr_if.data  <= data;
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic set_filter(logic [CSR_DATA_W-1:0] mode_d,
                             logic [CSR_DATA_W-1:0] thr_r, thr_g, thr_b,
                             logic [CSR_DATA_W-1:0] off_r, off_g, off_b);
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom_range(511)));
      write_csr(CSR_FILTER_MODE, mode_d);
      write_csr(CSR_THRESHOLD_RED, thr_r);
      write_csr(CSR_THRESHOLD_GREEN, thr_g);
      write_csr(CSR_THRESHOLD_BLUE, thr_b);
      write_csr(CSR_OFFSET_RED, off_r);
      write_csr(CSR_OFFSET_GREEN, off_g);
      write_csr(CSR_OFFSET_BLUE, off_b);
      csr_if.valid <= 1'b0;
   endtask

   // valid stays high between back-to-back pixels and drops only for a gap
   task automatic send_pixel(logic [PIXEL_W-1:0] p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.pixel_in <= p;
      req_if.valid    <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_pixel(p);
   endtask

   task automatic wait_idle();
      int n;
      n = 0;
      req_if.valid <= 1'b0;
      while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CHAN_W-1:0] pick_channel(logic [CHAN_W-1:0] thr);
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return CHAN_MAX;
         2:       return thr;
         3:       return thr - 8'd1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      if ($urandom_range(3) == 0)
         return PIXEL_W'($urandom);
      return {pick_channel(sb.thr_red), pick_channel(sb.thr_green),
              pick_channel(sb.thr_blue), CHAN_W'($urandom_range(255))};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      case ($urandom_range(3))
         0:       return {1'($urandom_range(1)), 8'h00};
         1:       return {1'($urandom_range(1)), CHAN_MAX};
         default: return CSR_DATA_W'($urandom_range(511));
      endcase
   endfunction

   // 9'h100 is -256, 9'h101 is -255, 9'h0ff is +255
   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      case ($urandom_range(5))
         0:       return 9'h100;
         1:       return 9'h101;
         2:       return 9'h0ff;
         3:       return 9'h000;
         default: return CSR_DATA_W'($urandom_range(511));
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] mode_d;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.pixel_in <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;
      set_idling(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: channel extremes and each mode
      set_filter(MODE_INVERT, 0, 0, 0, 0, 0, 0);
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'h1234_5678);
      wait_idle();
      // mean of 765, of 2 and of 764
      set_filter(MODE_MONO, 0, 0, 0, 0, 0, 0);
      send_pixel(32'hffff_ff00);
      send_pixel(32'h0101_00ff);
      send_pixel(32'hffff_fe80);
      wait_idle();
      set_filter(MODE_NIGHT, 0, 0, 0, 0, 0, 0);
      send_pixel(32'h8040_2011);
      send_pixel(32'hffff_ffff);
      wait_idle();
      // channels exactly at and one below the limit
      set_filter(MODE_THRESHOLD, 9'h080, 9'h180, 9'h080, 0, 0, 0);
      send_pixel(32'h8080_8080);
      send_pixel(32'h7f7f_7f7f);
      wait_idle();
      set_filter(MODE_OFFSET, 0, 0, 0, 9'h0ff, 9'h0ff, 9'h0ff);
      send_pixel(32'h0102_0304);
      send_pixel(32'h0000_00aa);
      wait_idle();
      set_filter(MODE_OFFSET, 0, 0, 0, 9'h100, 9'h101, 9'h1ff);
      send_pixel(32'hffff_ffff);
      send_pixel(32'hff00_0155);
      wait_idle();
      set_filter(MODE_SWAP_INVERT, 0, 0, 0, 0, 0, 0);
      send_pixel(32'h1122_3344);
      wait_idle();
      // unused mode codes pass the pixel through; upper data bits are ignored
      set_filter({6'h3f, MODE_SPARE_6}, 0, 0, 0, 0, 0, 0);
      send_pixel(32'hdead_beef);
      wait_idle();
      set_filter({6'h00, MODE_SPARE_7}, 0, 0, 0, 0, 0, 0);
      send_pixel(32'h0123_4567);
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_idling((ph + ph / 8) % 4);
         mode_d = {6'($urandom_range(63)), 3'(ph % 8)};
         set_filter(mode_d, pick_threshold(), pick_threshold(), pick_threshold(),
                    pick_offset(), pick_offset(), pick_offset());
         for (int i = 0; i < PIXELS_PER_PHASE; i++)
            send_pixel(random_pixel());
         wait_idle();
      end

      sb.flush_leftovers();
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
